FILE: rtl/asgr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package asgr_pkg;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_ESC    = 3'd1;
  localparam logic [2:0] PH_START  = 3'd2;
  localparam logic [2:0] PH_DIGITS = 3'd3;
  localparam logic [2:0] PH_SEP    = 3'd4;

  localparam logic [7:0] CH_ESC      = 8'h1b;
  localparam logic [7:0] CH_LBRACKET = 8'h5b;
  localparam logic [7:0] CH_ZERO     = 8'h30;

  localparam logic [3:0] DEFAULT_FG_RST = 4'd7;
  localparam logic [3:0] DEFAULT_BG_RST = 4'd0;

  localparam logic REG_DEFAULT_FG = 1'b0;
  localparam logic REG_DEFAULT_BG = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } in_item_t;

  typedef struct packed {
    logic [3:0] fg_color;
    logic [3:0] bg_color;
    logic       text_valid;
    logic [7:0] text_byte;
    logic       in_sequence;
  } out_item_t;

  typedef struct packed {
    logic [2:0] phase;
    logic [7:0] accum;
    logic [3:0] fg;
    logic [3:0] bg;
  } state_t;

  // ANSI color index to VGA palette index
  function automatic logic [2:0] vga_of_ansi(input logic [2:0] idx);
    logic [2:0] res;
    case (idx)
      3'd0: res = 3'd0;
      3'd1: res = 3'd4;
      3'd2: res = 3'd2;
      3'd3: res = 3'd6;
      3'd4: res = 3'd1;
      3'd5: res = 3'd5;
      3'd6: res = 3'd3;
      default: res = 3'd7;
    endcase
    return res;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/asgr_apply.sv
`timescale 1ns / 1ps
`default_nettype none
module asgr_apply (
  input  wire logic       apply_en,
  input  wire logic [7:0] code,
  input  wire logic [3:0] fg,
  input  wire logic [3:0] bg,
  input  wire logic [3:0] default_fg,
  input  wire logic [3:0] default_bg,
  output logic      [3:0] fg_nxt,
  output logic      [3:0] bg_nxt
);

  logic [7:0] off30;
  logic [7:0] off40;
  logic [7:0] off90;
  logic [7:0] off100;

  assign off30  = code - 8'd30;
  assign off40  = code - 8'd40;
  assign off90  = code - 8'd90;
  assign off100 = code - 8'd100;

  always_comb begin
    fg_nxt = fg;
    bg_nxt = bg;
    if (apply_en) begin
      if (code == 8'd0) begin
        fg_nxt = default_fg;
        bg_nxt = default_bg;
      end else if (code inside {[8'd30:8'd37]}) begin
        fg_nxt = {1'b0, asgr_pkg::vga_of_ansi(off30[2:0])};
      end else if (code inside {[8'd40:8'd47]}) begin
        bg_nxt = {1'b0, asgr_pkg::vga_of_ansi(off40[2:0])};
      end else if (code inside {[8'd90:8'd97]}) begin
        fg_nxt = {1'b1, asgr_pkg::vga_of_ansi(off90[2:0])};
      end else if (code inside {[8'd100:8'd107]}) begin
        bg_nxt = {1'b1, asgr_pkg::vga_of_ansi(off100[2:0])};
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/asgr_step.sv
`timescale 1ns / 1ps
`default_nettype none
module asgr_step (
  input  wire asgr_pkg::state_t   state,
  input  wire asgr_pkg::in_item_t item,
  input  wire logic [3:0]         default_fg,
  input  wire logic [3:0]         default_bg,
  output asgr_pkg::state_t        state_nxt,
  output asgr_pkg::out_item_t     result
);

  logic [7:0] b;
  logic       last;
  logic       digit;
  logic       fin;
  logic       ctrl;
  logic [7:0] dval;
  logic [2:0] ph;
  logic [7:0] acc;
  logic       text;
  logic       apply_en;
  logic [7:0] code;
  logic [3:0] fg_nxt;
  logic [3:0] bg_nxt;

  assign b     = item.data_byte;
  assign last  = item.buffer_end;
  assign digit = b inside {[8'h30:8'h39]};
  assign fin   = b inside {[8'h40:8'h7e]};
  assign ctrl  = (b < 8'h20) || (b >= 8'h80);
  assign dval  = b - asgr_pkg::CH_ZERO;

  always_comb begin
    ph       = state.phase;
    acc      = state.accum;
    text     = 1'b0;
    apply_en = 1'b0;
    code     = 8'd0;
    case (state.phase)
      asgr_pkg::PH_IDLE: begin
        if (b == asgr_pkg::CH_ESC && !last) begin
          ph = asgr_pkg::PH_ESC;
        end else begin
          text = 1'b1;
        end
      end
      asgr_pkg::PH_ESC: begin
        ph = (b == asgr_pkg::CH_LBRACKET) ? asgr_pkg::PH_START : asgr_pkg::PH_IDLE;
      end
      asgr_pkg::PH_START, asgr_pkg::PH_SEP: begin
        if (fin) begin
          ph = asgr_pkg::PH_IDLE;
        end else if (digit) begin
          acc = dval;
          ph  = asgr_pkg::PH_DIGITS;
        end else if (ctrl) begin
          apply_en = 1'b1;
          ph       = asgr_pkg::PH_IDLE;
        end else begin
          // an empty first field closed by a separator applies code 0
          apply_en = (state.phase == asgr_pkg::PH_START);
          ph       = asgr_pkg::PH_SEP;
        end
      end
      asgr_pkg::PH_DIGITS: begin
        if (digit) begin
          acc = {state.accum[4:0], 3'b000} + {state.accum[6:0], 1'b0} + dval;
        end else begin
          apply_en = 1'b1;
          code     = state.accum;
          ph       = (fin || ctrl) ? asgr_pkg::PH_IDLE : asgr_pkg::PH_SEP;
        end
      end
      default: begin
        // unused phase codes behave as idle
        if (b == asgr_pkg::CH_ESC && !last) begin
          ph = asgr_pkg::PH_ESC;
        end else begin
          ph   = asgr_pkg::PH_IDLE;
          text = 1'b1;
        end
      end
    endcase
    if (last) begin
      if (ph == asgr_pkg::PH_DIGITS) begin
        apply_en = 1'b1;
        code     = acc;
      end
      ph = asgr_pkg::PH_IDLE;
    end
  end

  asgr_apply u_apply (
    .apply_en   (apply_en),
    .code       (code),
    .fg         (state.fg),
    .bg         (state.bg),
    .default_fg (default_fg),
    .default_bg (default_bg),
    .fg_nxt     (fg_nxt),
    .bg_nxt     (bg_nxt)
  );

  always_comb begin
    state_nxt.phase    = ph;
    state_nxt.accum    = acc;
    state_nxt.fg       = fg_nxt;
    state_nxt.bg       = bg_nxt;
    result.fg_color    = fg_nxt;
    result.bg_color    = bg_nxt;
    result.text_valid  = text;
    result.text_byte   = text ? b : 8'h00;
    result.in_sequence = (ph != asgr_pkg::PH_IDLE);
  end

endmodule
`default_nettype wire

FILE: rtl/ansi_sgr_color_parser.sv
// ANSI SGR color parser.
// Input channel (in_valid/in_ready/in_data): one terminal byte per transaction,
// with buffer_end marking the last byte of a caller buffer.
// Result channel (out_valid/out_ready/out_data): exactly one result per input
// transaction, in order: current foreground/background VGA colors, the
// pass-through text byte with its valid flag, and the open-sequence flag.
// Configuration: APB-style port, default_fg at address 0, default_bg at 4.
// Write only while no transaction is in flight.
// Pipeline: an accepted byte is captured in an input register, and its result
// is then registered in the result register, which drives out_valid/out_data.
// Throughput: one byte per cycle while out_ready is high; the parser state
// update is combinational between the input and result registers.
// When out_ready is low, the result register holds, the input register fills,
// and in_ready drops once both are full; nothing is lost.
// Reset (rst_n low, synchronous): parser idle, colors and defaults return to
// foreground 7 and background 0, both pipeline registers empty.
`timescale 1ns / 1ps
`default_nettype none
module ansi_sgr_color_parser (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire asgr_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output asgr_pkg::out_item_t      out_data,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  logic                 s1_valid_r;
  asgr_pkg::in_item_t   s1_item_r;
  logic                 out_valid_r;
  asgr_pkg::out_item_t  out_item_r;
  asgr_pkg::state_t     state_r;
  asgr_pkg::state_t     state_nxt;
  asgr_pkg::out_item_t  result;
  logic [3:0]           default_fg_r;
  logic [3:0]           default_bg_r;
  logic                 advance;
  logic                 cfg_wr;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign cfg_wr   = psel && penable && pwrite;
  assign pready   = 1'b1;

  always_comb begin
    case (paddr[2])
      asgr_pkg::REG_DEFAULT_FG: prdata = {28'd0, default_fg_r};
      asgr_pkg::REG_DEFAULT_BG: prdata = {28'd0, default_bg_r};
      default:                  prdata = 32'd0;
    endcase
  end

  asgr_step u_step (
    .state      (state_r),
    .item       (s1_item_r),
    .default_fg (default_fg_r),
    .default_bg (default_bg_r),
    .state_nxt  (state_nxt),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_fg_r <= asgr_pkg::DEFAULT_FG_RST;
      default_bg_r <= asgr_pkg::DEFAULT_BG_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == asgr_pkg::REG_DEFAULT_FG) begin
        default_fg_r <= pwdata[3:0];
      end else begin
        default_bg_r <= pwdata[3:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      state_r.phase  <= asgr_pkg::PH_IDLE;
      state_r.accum  <= 8'd0;
      state_r.fg     <= asgr_pkg::DEFAULT_FG_RST;
      state_r.bg     <= asgr_pkg::DEFAULT_BG_RST;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
    if (advance) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule
`default_nettype wire

FILE: sim/tb_ansi_sgr_color_parser.sv
`timescale 1ns / 1ps
module tb_ansi_sgr_color_parser;

  localparam int          LIMIT_CYCLES = 400000;
  localparam int          HOLD_CYCLES  = 200;
  localparam int          PHASE_ITEMS  = 250;
  localparam logic [7:0]  CH_NINE      = 8'h39;
  localparam logic [7:0]  CH_SEMI      = 8'h3b;
  localparam logic [7:0]  CH_COLON     = 8'h3a;
  localparam logic [7:0]  CH_M         = 8'h6d;
  localparam logic [7:0]  CH_C         = 8'h63;
  localparam logic [7:0]  CH_BEL       = 8'h07;
  localparam logic [7:0]  CH_DEL       = 8'h7f;
  localparam logic [7:0]  CH_SPACE     = 8'h20;
  localparam logic [7:0]  SEP_HI       = 8'h2f;
  localparam logic [7:0]  SEP2_HI      = 8'h3f;
  localparam logic [7:0]  FINAL_LO     = 8'h40;
  localparam logic [7:0]  FINAL_HI     = 8'h7e;
  localparam logic [7:0]  HIGH_HALF    = 8'h80;
  localparam logic [7:0]  SGR_RESET    = 8'd0;
  localparam logic [7:0]  SGR_FG       = 8'd30;
  localparam logic [7:0]  SGR_BG       = 8'd40;
  localparam logic [7:0]  SGR_FG_HI    = 8'd90;
  localparam logic [7:0]  SGR_BG_HI    = 8'd100;

  class sgr_scoreboard;
    logic [3:0] dflt_fg, dflt_bg, cur_fg, cur_bg;
    logic [2:0] phase;
    logic [7:0] accum;
    asgr_pkg::out_item_t  expected_q[$];
    int         errors;
    int         results_seen;

    function new();
      dflt_fg = asgr_pkg::DEFAULT_FG_RST;
      dflt_bg = asgr_pkg::DEFAULT_BG_RST;
      cur_fg  = asgr_pkg::DEFAULT_FG_RST;
      cur_bg  = asgr_pkg::DEFAULT_BG_RST;
      phase   = asgr_pkg::PH_IDLE;
      accum   = '0;
    endfunction

    function void set_default(logic idx, logic [3:0] v);
      if (idx == asgr_pkg::REG_DEFAULT_FG) dflt_fg = v;
      else dflt_bg = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // ANSI color order maps to VGA order by reversing the three bits
    function logic [2:0] vga_index(logic [7:0] code, logic [7:0] base);
      logic [7:0] off;
      off = code - base;
      return {off[0], off[1], off[2]};
    endfunction

    function void apply_code(logic [7:0] code);
      if (code == SGR_RESET) begin
        cur_fg = dflt_fg;
        cur_bg = dflt_bg;
      end else if (code >= SGR_FG && code <= SGR_FG + 8'd7) begin
        cur_fg = {1'b0, vga_index(code, SGR_FG)};
      end else if (code >= SGR_BG && code <= SGR_BG + 8'd7) begin
        cur_bg = {1'b0, vga_index(code, SGR_BG)};
      end else if (code >= SGR_FG_HI && code <= SGR_FG_HI + 8'd7) begin
        cur_fg = {1'b1, vga_index(code, SGR_FG_HI)};
      end else if (code >= SGR_BG_HI && code <= SGR_BG_HI + 8'd7) begin
        cur_bg = {1'b1, vga_index(code, SGR_BG_HI)};
      end
    endfunction

    function void note_byte(asgr_pkg::in_item_t it);
      logic [7:0] b;
      logic       last, is_digit, is_final, is_ctrl, show;
      logic [2:0] ph;
      asgr_pkg::out_item_t  r;
      b        = it.data_byte;
      last     = it.buffer_end;
      is_digit = (b >= asgr_pkg::CH_ZERO) && (b <= CH_NINE);
      is_final = (b >= FINAL_LO) && (b <= FINAL_HI);
      is_ctrl  = (b < CH_SPACE) || (b >= HIGH_HALF);
      show     = 1'b0;
      ph       = (phase > asgr_pkg::PH_SEP) ? asgr_pkg::PH_IDLE : phase;
      case (ph)
        asgr_pkg::PH_IDLE: begin
          if (b == asgr_pkg::CH_ESC && !last) ph = asgr_pkg::PH_ESC;
          else show = 1'b1;
        end
        asgr_pkg::PH_ESC: begin
          ph = (b == asgr_pkg::CH_LBRACKET) ? asgr_pkg::PH_START : asgr_pkg::PH_IDLE;
        end
        asgr_pkg::PH_START, asgr_pkg::PH_SEP: begin
          if (is_final) begin
            ph = asgr_pkg::PH_IDLE;
          end else if (is_digit) begin
            accum = b - asgr_pkg::CH_ZERO;
            ph = asgr_pkg::PH_DIGITS;
          end else if (is_ctrl) begin
            apply_code(SGR_RESET);
            ph = asgr_pkg::PH_IDLE;
          end else begin
            if (ph == asgr_pkg::PH_START) apply_code(SGR_RESET);
            ph = asgr_pkg::PH_SEP;
          end
        end
        default: begin
          if (is_digit) begin
            accum = accum * 8'd10 + (b - asgr_pkg::CH_ZERO);
          end else begin
            apply_code(accum);
            ph = (is_final || is_ctrl) ? asgr_pkg::PH_IDLE : asgr_pkg::PH_SEP;
          end
        end
      endcase
      if (last) begin
        if (ph == asgr_pkg::PH_DIGITS) apply_code(accum);
        ph = asgr_pkg::PH_IDLE;
      end
      phase         = ph;
      r.fg_color    = cur_fg;
      r.bg_color    = cur_bg;
      r.text_valid  = show;
      r.text_byte   = show ? b : 8'h00;
      r.in_sequence = (ph != asgr_pkg::PH_IDLE);
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task cmp_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        report($sformatf("result %0d %s = 0x%0h, expected 0x%0h",
                         results_seen, name, got, want));
    endtask

    task check_result(asgr_pkg::out_item_t got);
      asgr_pkg::out_item_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", results_seen));
        return;
      end
      want = expected_q.pop_front();
      cmp_field("fg_color", 8'(got.fg_color), 8'(want.fg_color));
      cmp_field("bg_color", 8'(got.bg_color), 8'(want.bg_color));
      cmp_field("text_valid", 8'(got.text_valid), 8'(want.text_valid));
      cmp_field("text_byte", got.text_byte, want.text_byte);
      cmp_field("in_sequence", 8'(got.in_sequence), 8'(want.in_sequence));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  asgr_pkg::in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  asgr_pkg::out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sgr_scoreboard sb;
  int          items_sent  = 0;
  int          cfg_writes  = 0;
  int          cycle_cnt   = 0;
  int unsigned tx_gap_pct  = 0;
  int unsigned rx_stall_pct = 0;
  bit          hold_req    = 1'b0;
  bit          hold_done   = 1'b0;

  ansi_sgr_color_parser u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, sb.pending());
      $display("** ansi_sgr_color_parser: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // result side: random stalls, plus one long hold-off to back up the pipeline
  initial begin
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_ready <= 1'b1;
      end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    asgr_pkg::in_item_t it;
    int       gap;
    it.data_byte  = b;
    it.buffer_end = last;
    gap = 0;
    if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) gap = $urandom_range(1, 14);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_byte(it);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [3:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {28'($urandom), v};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.set_default(idx, v);
    cfg_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_idle(input int settle);
    while (sb.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic rare_last();
    return ($urandom_range(0, 31) == 0);
  endfunction

  function automatic logic [7:0] sep_byte();
    case ($urandom_range(0, 2))
      0:       return 8'($urandom_range(CH_SPACE, SEP_HI));
      1:       return 8'($urandom_range(CH_COLON, SEP2_HI));
      default: return CH_DEL;
    endcase
  endfunction

  function automatic logic [7:0] ctrl_byte();
    if ($urandom_range(0, 1)) return 8'($urandom_range(0, 31));
    return 8'($urandom_range(128, 255));
  endfunction

  function automatic int unsigned pick_code();
    case ($urandom_range(0, 9))
      0:       return 0;
      1, 2:    return 30 + $urandom_range(0, 7);
      3:       return 40 + $urandom_range(0, 7);
      4:       return 90 + $urandom_range(0, 7);
      5:       return 100 + $urandom_range(0, 7);
      6:       return $urandom_range(0, 999);
      7:       return 286 + $urandom_range(0, 21);  // wraps onto color codes
      8:       return $urandom_range(0, 255);
      default: return $urandom_range(0, 120);
    endcase
  endfunction

  task automatic send_number(input int unsigned v);
    if ($urandom_range(0, 7) == 0) send_byte(asgr_pkg::CH_ZERO, rare_last());
    if (v >= 100) send_byte(asgr_pkg::CH_ZERO + 8'(v / 100), rare_last());
    if (v >= 10) send_byte(asgr_pkg::CH_ZERO + 8'((v / 10) % 10), rare_last());
    send_byte(asgr_pkg::CH_ZERO + 8'(v % 10), rare_last());
  endtask

  task automatic send_csi();
    int unsigned nf;
    send_byte(asgr_pkg::CH_ESC, 1'b0);
    send_byte(asgr_pkg::CH_LBRACKET, rare_last());
    nf = $urandom_range(0, 4);
    for (int k = 0; k < nf; k++) begin
      if (k != 0) begin
        send_byte(($urandom_range(0, 3) == 0) ? sep_byte() : CH_SEMI, rare_last());
        if ($urandom_range(0, 7) == 0) send_byte(sep_byte(), rare_last());
      end
      if ($urandom_range(0, 5) != 0) send_number(pick_code());
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: send_byte(CH_M, 1'b0);
      6:       send_byte(8'($urandom_range(FINAL_LO, FINAL_HI)), 1'b0);
      7:       send_byte(ctrl_byte(), 1'b0);
      8:       send_byte(asgr_pkg::CH_ZERO + 8'($urandom_range(0, 9)), 1'b1);
      default: begin
        send_byte(sep_byte(), 1'b0);
        send_byte($urandom_range(0, 1) ? CH_M : ctrl_byte(), 1'b0);
      end
    endcase
  endtask

  task automatic random_chunk();
    int unsigned kind;
    kind = $urandom_range(0, 9);
    if (kind < 5) begin
      send_csi();
    end else if (kind < 8) begin
      repeat ($urandom_range(1, 6))
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    end else if (kind == 8) begin
      send_byte(asgr_pkg::CH_ESC, 1'b0);
      send_byte(8'($urandom_range(0, 255)), rare_last());
    end else begin
      send_byte(asgr_pkg::CH_ESC, 1'b0);
      send_byte(asgr_pkg::CH_LBRACKET, 1'b0);
      repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)), rare_last());
    end
  endtask

  initial begin
    logic [3:0] fg_set, bg_set;
    int         stop_at;
    sb       = new();
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: text extremes, escape corner cases, reset defaults in force
    rx_stall_pct = 20;
    send_byte(8'h00, 1'b0); send_byte(8'hff, 1'b1); send_byte(8'h41, 1'b0);
    send_byte(asgr_pkg::CH_ESC, 1'b1);
    send_byte(asgr_pkg::CH_ESC, 1'b0); send_byte(CH_C, 1'b0);
    send_byte(asgr_pkg::CH_ESC, 1'b0); send_byte(asgr_pkg::CH_LBRACKET, 1'b0);
    send_byte(asgr_pkg::CH_ZERO + 8'd3, 1'b0); send_byte(asgr_pkg::CH_ZERO + 8'd1, 1'b0);
    send_byte(CH_M, 1'b0);
    send_byte(asgr_pkg::CH_ESC, 1'b0); send_byte(asgr_pkg::CH_LBRACKET, 1'b0);
    send_byte(CH_SEMI, 1'b0);
    send_byte(asgr_pkg::CH_ZERO + 8'd1, 1'b0); send_byte(asgr_pkg::CH_ZERO, 1'b0);
    send_byte(asgr_pkg::CH_ZERO + 8'd3, 1'b0);
    send_byte(CH_COLON, 1'b0); send_byte(CH_BEL, 1'b0);
    send_byte(asgr_pkg::CH_ESC, 1'b0); send_byte(asgr_pkg::CH_LBRACKET, 1'b0);
    send_byte(CH_M, 1'b0);
    send_byte(asgr_pkg::CH_ESC, 1'b0); send_byte(asgr_pkg::CH_LBRACKET, 1'b0);
    send_byte(asgr_pkg::CH_ZERO + 8'd9, 1'b0); send_byte(asgr_pkg::CH_ZERO + 8'd7, 1'b1);
    send_byte(asgr_pkg::CH_ESC, 1'b0); send_byte(asgr_pkg::CH_LBRACKET, 1'b1);
    in_valid <= 1'b0;

    for (int p = 0; p < 6; p++) begin
      wait_idle(4);
      case (p)
        0:       begin fg_set = 4'hf; bg_set = 4'hf; end
        1:       begin fg_set = 4'h0; bg_set = 4'h0; end
        2:       begin fg_set = 4'hf; bg_set = 4'h0; end
        3:       begin fg_set = 4'h0; bg_set = 4'hf; end
        default: begin fg_set = 4'($urandom); bg_set = 4'($urandom); end
      endcase
      write_reg(asgr_pkg::REG_DEFAULT_FG, fg_set);
      write_reg(asgr_pkg::REG_DEFAULT_BG, bg_set);
      tx_gap_pct   = (p == 5) ? 0 : 15;
      rx_stall_pct = (p == 5) ? 0 : 15;
      stop_at = items_sent + PHASE_ITEMS;
      while (items_sent < stop_at) begin
        if (p == 2 && !hold_done && items_sent >= stop_at - 150) begin
          hold_req  = 1'b1;
          hold_done = 1'b1;
        end
        if (p != 5 && $urandom_range(0, 19) == 0) begin
          tx_gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
          rx_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
        end
        random_chunk();
      end
      in_valid <= 1'b0;
    end

    wait_idle(10);
    $display("Ran %0d bytes through the parser, %0d results compared, %0d register writes",
             items_sent, sb.results_seen, cfg_writes);
    $display("including escape corner cases, wrapped parameters and a %0d-cycle output hold",
             HOLD_CYCLES);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** ansi_sgr_color_parser: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.pending());
      $display("** ansi_sgr_color_parser: FAILED **");
    end
    $finish;
  end

endmodule
